FILE: src/smpc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package smpc_pkg;

    // word and gain widths of the datapath
    localparam int SMPC_DATA_W = 32;
    localparam int SMPC_GAIN_W = 31;

    // default fixed-point fraction
    localparam int SMPC_FRAC_BITS = 16;

    // multiplier request from the sequencer
    typedef struct packed {
        logic                          start;
        logic [SMPC_GAIN_W-1:0]        gain;
        logic signed [SMPC_DATA_W-1:0] x;
    } smpc_mul_req_t;

    // multiplier status back to the sequencer
    typedef struct packed {
        logic                          busy;
        logic                          done;
        logic signed [SMPC_DATA_W-1:0] product;
    } smpc_mul_rsp_t;

endpackage

`default_nettype wire

FILE: src/smpc_mul.sv
`timescale 1ns / 1ps
`default_nettype none

module smpc_mul import smpc_pkg::*; #(
    parameter int FRAC_BITS = SMPC_FRAC_BITS
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire smpc_mul_req_t req,
    output smpc_mul_rsp_t      rsp
);

    // radix-4: two gain bits per cycle
    localparam int DIGITS = (SMPC_GAIN_W + 1) / 2;
    localparam int CNT_W  = $clog2(DIGITS);
    localparam int ACC_W  = SMPC_DATA_W + 4;
    localparam int LO_W   = 2 * DIGITS;
    localparam int PROD_W = ACC_W + LO_W;
    localparam int Q_W    = PROD_W - FRAC_BITS;
    localparam int HI_W   = Q_W - SMPC_DATA_W + 1;

    logic [LO_W-1:0]          gain_sh_reg, gain_sh_next;
    logic signed [ACC_W-1:0]  x1_reg, x1_next;
    logic signed [ACC_W-1:0]  x3_reg, x3_next;
    logic signed [ACC_W-1:0]  acc_hi_reg, acc_hi_next;
    logic [LO_W-1:0]          acc_lo_reg, acc_lo_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;

    logic signed [ACC_W-1:0]  x_ext;
    logic signed [ACC_W-1:0]  addend;
    logic signed [ACC_W-1:0]  partial;
    logic signed [PROD_W-1:0] prod;
    logic [Q_W-1:0]           quot;
    logic [HI_W-1:0]          quot_hi;
    logic                     fits;

    assign x_ext = ACC_W'(req.x);

    always_comb begin
        case (gain_sh_reg[1:0])
            2'd0:    addend = '0;
            2'd1:    addend = x1_reg;
            2'd2:    addend = x1_reg <<< 1;
            2'd3:    addend = x3_reg;
            default: addend = '0;
        endcase
    end

    assign partial = acc_hi_reg + addend;

    always_comb begin
        gain_sh_next = gain_sh_reg;
        x1_next      = x1_reg;
        x3_next      = x3_reg;
        acc_hi_next  = acc_hi_reg;
        acc_lo_next  = acc_lo_reg;
        cnt_next     = cnt_reg;
        busy_next    = busy_reg;
        done_next    = 1'b0;
        if (req.start) begin
            gain_sh_next = LO_W'(req.gain);
            x1_next      = x_ext;
            x3_next      = x_ext + (x_ext <<< 1);
            acc_hi_next  = '0;
            acc_lo_next  = '0;
            cnt_next     = '0;
            busy_next    = 1'b1;
        end else if (busy_reg) begin
            gain_sh_next = gain_sh_reg >> 2;
            acc_hi_next  = partial >>> 2;
            acc_lo_next  = {partial[1:0], acc_lo_reg[LO_W-1:2]};
            cnt_next     = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DIGITS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        gain_sh_reg <= gain_sh_next;
        x1_reg      <= x1_next;
        x3_reg      <= x3_next;
        acc_hi_reg  <= acc_hi_next;
        acc_lo_reg  <= acc_lo_next;
    end

    // floor shift, then saturate to one word
    assign prod    = {acc_hi_reg, acc_lo_reg};
    assign quot    = prod[PROD_W-1:FRAC_BITS];
    assign quot_hi = quot[Q_W-1:SMPC_DATA_W-1];
    assign fits    = (&quot_hi) | ~(|quot_hi);

    always_comb begin
        rsp.busy = busy_reg;
        rsp.done = done_reg;
        if (fits) begin
            rsp.product = quot[SMPC_DATA_W-1:0];
        end else if (quot[Q_W-1]) begin
            rsp.product = {1'b1, {(SMPC_DATA_W-1){1'b0}}};
        end else begin
            rsp.product = {1'b0, {(SMPC_DATA_W-1){1'b1}}};
        end
    end

endmodule

`default_nettype wire

FILE: src/sliding_mode_position_controller.sv
`timescale 1ns / 1ps
`default_nettype none

// sliding-mode position controller, signed fixed point with FRAC_BITS fraction
// bits (Q16.16 by default). each input word carries target angle, measured
// angle and measured velocity; each produces one output word with the drive
// and two flags (in dead band, clamped). all five gain products go one after
// another through a single shared radix-4 serial multiplier that retires two
// gain bits a cycle; the sequencer starts each product, waits until the
// multiplier signals done and takes the product back before it starts the
// next one. a word inside the dead band goes out with no product at all.
// the output word sits in its own register, so the next input word can be
// taken while a finished result still waits on m_tready. gains and limits sit
// in six 31-bit registers on the apb port at byte addresses 0, 4, .. 20:
// surface slope, reaching gain, dead band, drive limit, inertia gain,
// switching gain. write them only while the block is idle.

module sliding_mode_position_controller import smpc_pkg::*; #(
    parameter int FRAC_BITS = SMPC_FRAC_BITS
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // input stream
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [95:0]  s_tdata,   // target_angle, measured_angle, measured_velocity
    // output stream
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [31:0]       m_tdata,   // drive
    output logic [1:0]        m_tuser,   // in_dead_band, clamped
    // configuration
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [4:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int W   = SMPC_DATA_W;
    localparam int GW  = SMPC_GAIN_W;
    localparam int EW  = W + 4;          // width for exact sums before saturation
    localparam int IW  = W + 3;          // inner sum accumulator

    // register map
    localparam logic [2:0] RI_SLOPE   = 3'd0;
    localparam logic [2:0] RI_REACH   = 3'd1;
    localparam logic [2:0] RI_BAND    = 3'd2;
    localparam logic [2:0] RI_LIMIT   = 3'd3;
    localparam logic [2:0] RI_INERTIA = 3'd4;
    localparam logic [2:0] RI_SWITCH  = 3'd5;

    localparam logic [GW-1:0] RST_SLOPE   = GW'(1310720);
    localparam logic [GW-1:0] RST_REACH   = GW'(7864320);
    localparam logic [GW-1:0] RST_BAND    = GW'(66);
    localparam logic [GW-1:0] RST_LIMIT   = GW'(1638400000);
    localparam logic [GW-1:0] RST_INERTIA = GW'(52429);
    localparam logic [GW-1:0] RST_SWITCH  = GW'(32768);

    // sequencer states
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIFF = 3'd1;
    localparam logic [2:0] ST_BAND = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_WAIT = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    // product order through the shared multiplier
    localparam logic [2:0] MI_C_ERR = 3'd0;
    localparam logic [2:0] MI_C_REL = 3'd1;
    localparam logic [2:0] MI_E_SAT = 3'd2;
    localparam logic [2:0] MI_K_S   = 3'd3;
    localparam logic [2:0] MI_J_IN  = 3'd4;

    localparam logic signed [EW-1:0] WORD_MAX = EW'(64'sd2147483647);
    localparam logic signed [EW-1:0] WORD_MIN = EW'(-64'sd2147483648);
    localparam logic signed [EW-1:0] ONE      = EW'(1) <<< FRAC_BITS;

    function automatic logic signed [EW-1:0] ext(input logic [W-1:0] w);
        ext = EW'($signed(w));
    endfunction

    function automatic logic [W-1:0] sat_word(input logic signed [EW-1:0] v);
        if (v > WORD_MAX) begin
            sat_word = WORD_MAX[W-1:0];
        end else if (v < WORD_MIN) begin
            sat_word = WORD_MIN[W-1:0];
        end else begin
            sat_word = v[W-1:0];
        end
    endfunction

    // configuration registers
    logic [GW-1:0] slope_reg, reach_reg, band_reg, limit_reg, inertia_reg, switch_reg;
    logic          cfg_write;
    logic [2:0]    cfg_idx;

    // sequencer and datapath
    logic [2:0]           state_reg, state_next;
    logic [2:0]           mul_idx_reg, mul_idx_next;
    logic [W-1:0]         target_reg, target_next;
    logic [W-1:0]         angle_reg, angle_next;
    logic [W-1:0]         velocity_reg, velocity_next;
    logic [W-1:0]         err_reg, err_next;
    logic [W-1:0]         step_reg, step_next;
    logic [W-1:0]         rel_reg, rel_next;
    logic [W-1:0]         surf_reg, surf_next;
    logic signed [IW-1:0] inner_reg, inner_next;
    logic [W-1:0]         last_target_reg, last_target_next;
    logic [W-1:0]         last_step_reg, last_step_next;
    logic [W-1:0]         drive_reg, drive_next;
    logic                 band_flag_reg, band_flag_next;
    logic                 clamp_flag_reg, clamp_flag_next;

    // output word register
    logic                 m_valid_reg, m_valid_next;
    logic [W-1:0]         m_drive_reg, m_drive_next;
    logic [1:0]           m_user_reg, m_user_next;

    smpc_mul_req_t        mul_req;
    smpc_mul_rsp_t        mul_rsp;

    logic signed [EW-1:0] err_mag;
    logic [W-1:0]         sat_surf;
    logic [W-1:0]         inner_word;
    logic signed [EW-1:0] drv_raw;
    logic signed [EW-1:0] lim_pos;
    logic [W-1:0]         drv_clamped;
    logic                 drv_clip;
    logic                 out_free;

    // ---------------------------------------------------------------- apb port
    assign pready    = 1'b1;
    assign cfg_idx   = paddr[4:2];
    assign cfg_write = psel & penable & pwrite & pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slope_reg   <= RST_SLOPE;
            reach_reg   <= RST_REACH;
            band_reg    <= RST_BAND;
            limit_reg   <= RST_LIMIT;
            inertia_reg <= RST_INERTIA;
            switch_reg  <= RST_SWITCH;
        end else if (cfg_write) begin
            case (cfg_idx)
                RI_SLOPE:   slope_reg   <= pwdata[GW-1:0];
                RI_REACH:   reach_reg   <= pwdata[GW-1:0];
                RI_BAND:    band_reg    <= pwdata[GW-1:0];
                RI_LIMIT:   limit_reg   <= pwdata[GW-1:0];
                RI_INERTIA: inertia_reg <= pwdata[GW-1:0];
                RI_SWITCH:  switch_reg  <= pwdata[GW-1:0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            RI_SLOPE:   prdata = {1'b0, slope_reg};
            RI_REACH:   prdata = {1'b0, reach_reg};
            RI_BAND:    prdata = {1'b0, band_reg};
            RI_LIMIT:   prdata = {1'b0, limit_reg};
            RI_INERTIA: prdata = {1'b0, inertia_reg};
            RI_SWITCH:  prdata = {1'b0, switch_reg};
            default:    prdata = '0;
        endcase
    end

    // ---------------------------------------------------------- shared multiplier
    // sat(S) clipped to +-1.0
    always_comb begin
        if (ext(surf_reg) > ONE) begin
            sat_surf = ONE[W-1:0];
        end else if (ext(surf_reg) < -ONE) begin
            sat_surf = sat_word(-ONE);
        end else begin
            sat_surf = surf_reg;
        end
    end

    assign inner_word = sat_word(EW'(inner_reg));

    always_comb begin
        mul_req.start = (state_reg == ST_MUL);
        case (mul_idx_reg)
            MI_C_ERR: begin
                mul_req.gain = slope_reg;
                mul_req.x    = err_reg;
            end
            MI_C_REL: begin
                mul_req.gain = slope_reg;
                mul_req.x    = rel_reg;
            end
            MI_E_SAT: begin
                mul_req.gain = switch_reg;
                mul_req.x    = sat_surf;
            end
            MI_K_S: begin
                mul_req.gain = reach_reg;
                mul_req.x    = surf_reg;
            end
            MI_J_IN: begin
                mul_req.gain = inertia_reg;
                mul_req.x    = inner_word;
            end
            default: begin
                mul_req.gain = '0;
                mul_req.x    = '0;
            end
        endcase
    end

    smpc_mul #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mul_req),
        .rsp     (mul_rsp)
    );

    // ----------------------------------------------------------- drive and clamp
    assign err_mag = err_reg[W-1] ? -ext(err_reg) : ext(err_reg);
    assign drv_raw = -ext(mul_rsp.product);
    assign lim_pos = EW'(limit_reg);

    always_comb begin
        drv_clip = 1'b0;
        if (drv_raw > lim_pos) begin
            drv_clamped = lim_pos[W-1:0];
            drv_clip    = 1'b1;
        end else if (drv_raw < -lim_pos) begin
            drv_clamped = sat_word(-lim_pos);
            drv_clip    = 1'b1;
        end else begin
            drv_clamped = drv_raw[W-1:0];
        end
    end

    // --------------------------------------------------------------- sequencer
    assign s_tready = (state_reg == ST_IDLE);
    assign out_free = !m_valid_reg || m_tready;

    always_comb begin
        state_next       = state_reg;
        mul_idx_next     = mul_idx_reg;
        target_next      = target_reg;
        angle_next       = angle_reg;
        velocity_next    = velocity_reg;
        err_next         = err_reg;
        step_next        = step_reg;
        rel_next         = rel_reg;
        surf_next        = surf_reg;
        inner_next       = inner_reg;
        last_target_next = last_target_reg;
        last_step_next   = last_step_reg;
        drive_next       = drive_reg;
        band_flag_next   = band_flag_reg;
        clamp_flag_next  = clamp_flag_reg;
        m_valid_next     = m_valid_reg && !m_tready;
        m_drive_next     = m_drive_reg;
        m_user_next      = m_user_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    target_next   = s_tdata[W-1:0];
                    angle_next    = s_tdata[2*W-1:W];
                    velocity_next = s_tdata[3*W-1:2*W];
                    state_next    = ST_DIFF;
                end
            end
            ST_DIFF: begin
                // error and target step
                err_next  = sat_word(ext(angle_reg) - ext(target_reg));
                step_next = sat_word(ext(target_reg) - ext(last_target_reg));
                state_next = ST_BAND;
            end
            ST_BAND: begin
                // inner sum starts from the target's second difference
                inner_next     = IW'(ext(sat_word(ext(step_reg) - ext(last_step_reg))));
                rel_next       = sat_word(ext(velocity_reg) - ext(step_reg));
                last_step_next = step_reg;
                mul_idx_next   = MI_C_ERR;
                if (err_mag < EW'(band_reg)) begin
                    drive_next      = '0;
                    band_flag_next  = 1'b1;
                    clamp_flag_next = 1'b0;
                    state_next      = ST_OUT;
                end else begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                state_next = ST_WAIT;
            end
            ST_WAIT: begin
                if (mul_rsp.done) begin
                    state_next   = ST_MUL;
                    mul_idx_next = mul_idx_reg + 1'b1;
                    case (mul_idx_reg)
                        MI_C_ERR: surf_next  = sat_word(ext(mul_rsp.product) + ext(rel_reg));
                        MI_C_REL: inner_next = inner_reg - IW'(ext(mul_rsp.product));
                        MI_E_SAT: inner_next = inner_reg - IW'(ext(mul_rsp.product));
                        MI_K_S:   inner_next = inner_reg - IW'(ext(mul_rsp.product));
                        MI_J_IN: begin
                            drive_next       = drv_clamped;
                            clamp_flag_next  = drv_clip;
                            band_flag_next   = 1'b0;
                            last_target_next = target_reg;
                            mul_idx_next     = MI_C_ERR;
                            state_next       = ST_OUT;
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_OUT: begin
                // park here while the previous word still waits downstream
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_drive_next = drive_reg;
                    m_user_next  = {clamp_flag_reg, band_flag_reg};
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            mul_idx_reg     <= MI_C_ERR;
            last_target_reg <= '0;
            last_step_reg   <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            mul_idx_reg     <= mul_idx_next;
            last_target_reg <= last_target_next;
            last_step_reg   <= last_step_next;
            m_valid_reg     <= m_valid_next;
        end
        target_reg     <= target_next;
        angle_reg      <= angle_next;
        velocity_reg   <= velocity_next;
        err_reg        <= err_next;
        step_reg       <= step_next;
        rel_reg        <= rel_next;
        surf_reg       <= surf_next;
        inner_reg      <= inner_next;
        drive_reg      <= drive_next;
        band_flag_reg  <= band_flag_next;
        clamp_flag_reg <= clamp_flag_next;
        m_drive_reg    <= m_drive_next;
        m_user_reg     <= m_user_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_drive_reg;
    assign m_tuser  = m_user_reg;

    // --------------------------------------------------------------- assertions
    // multiplier only runs while the sequencer waits on it
    assert property (@(posedge aclk) disable iff (!aresetn)
        mul_rsp.busy |-> (state_reg == ST_WAIT))
        else $error("multiplier busy outside wait state");

    // an accepted word always starts the difference stage
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == ST_DIFF))
        else $error("accepted word did not start processing");

    // a dead band result is never also clamped
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("dead band and clamp flags both set");

    // a clamped drive sits exactly on the limit
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[1]) |->
            ((m_tdata == {1'b0, limit_reg}) || (m_tdata == (~{1'b0, limit_reg} + 1'b1))))
        else $error("clamped drive off the limit");

endmodule

`default_nettype wire

FILE: tb/sv/sliding_mode_position_controller_tb.sv
`timescale 1ns / 1ps

module sliding_mode_position_controller_tb;
    import smpc_pkg::*;

    localparam int FRAC      = SMPC_FRAC_BITS;
    localparam int HOLD_LEN  = 500;   // long output hold, in cycles
    localparam int DRAIN_PAD = 150;   // margin beyond the worst case per word
    localparam int STALL_MAX = 4000;  // cycles with no word moving before giving up
    localparam int MAX_SHOWN = 40;

    // register indexes, byte address is 4 * index
    localparam int REG_SURFACE_SLOPE  = 0;
    localparam int REG_REACHING_GAIN  = 1;
    localparam int REG_DEAD_BAND      = 2;
    localparam int REG_DRIVE_LIMIT    = 3;
    localparam int REG_INERTIA_GAIN   = 4;
    localparam int REG_SWITCHING_GAIN = 5;
    localparam int REG_UNMAPPED_LO    = 6;
    localparam int REG_UNMAPPED_HI    = 7;

    localparam logic signed [63:0] WORD_MAX = 64'sd2147483647;
    localparam logic signed [63:0] WORD_MIN = -64'sd2147483648;
    localparam logic signed [63:0] UNIT     = 64'sd1 <<< FRAC;

    // input word, laid out as on s_tdata (target in the low bits)
    typedef struct packed {
        logic signed [31:0] velocity;
        logic signed [31:0] measured;
        logic signed [31:0] target;
    } angle_word_t;

    typedef struct packed {
        logic signed [31:0] drive;
        logic               dead;
        logic               clamped;
    } drive_word_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    wire logic   s_tready;
    logic [95:0] s_tdata  = '0;
    wire logic   m_tvalid;
    logic        m_tready = 1'b0;
    wire logic [31:0] m_tdata;
    wire logic [1:0]  m_tuser;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [4:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    wire logic [31:0] prdata;
    wire logic   pready;

    sliding_mode_position_controller #(.FRAC_BITS(FRAC)) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #10 aclk = ~aclk;

    // predictor copy of the gain registers, reset values
    logic [30:0] gain_reg [6] = '{31'd1310720, 31'd7864320, 31'd66,
                                  31'd1638400000, 31'd52429, 31'd32768};
    // predictor copy of the target history
    logic signed [31:0] prev_target = '0;
    logic signed [31:0] prev_step   = '0;

    angle_word_t angle_pending [$];
    drive_word_t drive_expect  [$];

    int  src_idle_pct   = 0;
    int  sink_stall_pct = 0;
    int  hold_requests  = 0;
    int  holds_served   = 0;
    int  hold_left      = 0;
    logic in_taken      = 1'b0;

    int  mismatches     = 0;
    int  words_checked  = 0;
    int  dead_seen      = 0;
    int  clamp_seen     = 0;
    int  quiet_cycles   = 0;

    // random trajectory for well-formed motion
    int  traj_pos  = 0;
    int  traj_rate = 0;

    task automatic flag_mismatch(input string msg);
        if (mismatches < MAX_SHOWN)
            $display("mismatch at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    function automatic logic signed [63:0] sat_word(input logic signed [63:0] v);
        if (v > WORD_MAX) return WORD_MAX;
        if (v < WORD_MIN) return WORD_MIN;
        return v;
    endfunction

    // unsigned gain times signed word, floor shift, saturate
    function automatic logic signed [63:0] gain_mul(input logic [30:0] g,
                                                   input logic signed [63:0] x);
        logic signed [63:0] p;
        p = $signed({33'd0, g}) * x;
        return sat_word(p >>> FRAC);
    endfunction

    // expected drive word for one accepted input word, advances the history
    function automatic drive_word_t predict_drive(input angle_word_t w);
        logic signed [63:0] tgt, ang, vel, err, stp, ddref, mag;
        logic signed [63:0] rel, s, sats, inner, drv, lim;
        drive_word_t r;
        tgt   = w.target;
        ang   = w.measured;
        vel   = w.velocity;
        err   = sat_word(ang - tgt);
        stp   = sat_word(tgt - prev_target);
        ddref = sat_word(stp - prev_step);
        mag   = (err < 0) ? -err : err;
        r     = '0;
        prev_step = stp[31:0];
        // inside the dead band the target history keeps the old target
        if (mag < $signed({33'd0, gain_reg[REG_DEAD_BAND]})) begin
            r.dead = 1'b1;
            return r;
        end
        rel   = sat_word(vel - stp);
        s     = sat_word(gain_mul(gain_reg[REG_SURFACE_SLOPE], err) + rel);
        sats  = (s > UNIT) ? UNIT : ((s < -UNIT) ? -UNIT : s);
        inner = sat_word(ddref - gain_mul(gain_reg[REG_SURFACE_SLOPE], rel)
                         - gain_mul(gain_reg[REG_SWITCHING_GAIN], sats)
                         - gain_mul(gain_reg[REG_REACHING_GAIN], s));
        drv   = -gain_mul(gain_reg[REG_INERTIA_GAIN], inner);
        lim   = $signed({33'd0, gain_reg[REG_DRIVE_LIMIT]});
        if (drv > lim) begin
            drv = lim;
            r.clamped = 1'b1;
        end else if (drv < -lim) begin
            drv = -lim;
            r.clamped = 1'b1;
        end
        prev_target = w.target;
        r.drive = drv[31:0];
        return r;
    endfunction

    // driver: next word goes out at the falling edge once the last one was taken
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || in_taken) begin
            if (angle_pending.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                s_tdata  <= angle_pending.pop_front();
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: random stalls, plus a long hold on request
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (holds_served != hold_requests) begin
            holds_served <= holds_served + 1;
            hold_left    <= HOLD_LEN;
            m_tready     <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // monitor: predict on input accept, check on output accept, watchdog
    always @(posedge aclk) begin
        drive_word_t exp_w;
        in_taken <= aresetn && s_tvalid && s_tready;
        if (aresetn) begin
            if (s_tvalid && s_tready)
                drive_expect.push_back(predict_drive(angle_word_t'(s_tdata)));
            if (m_tvalid && m_tready) begin
                if (drive_expect.size() == 0) begin
                    flag_mismatch($sformatf("drive word %h/%b with nothing expected",
                                            m_tdata, m_tuser));
                end else begin
                    exp_w = drive_expect.pop_front();
                    words_checked++;
                    if (exp_w.dead) dead_seen++;
                    if (exp_w.clamped) clamp_seen++;
                    if (m_tdata !== exp_w.drive)
                        flag_mismatch($sformatf("word %0d drive %h, expected %h",
                                                words_checked, m_tdata, exp_w.drive));
                    if (m_tuser[0] !== exp_w.dead)
                        flag_mismatch($sformatf("word %0d in_dead_band %b, expected %b",
                                                words_checked, m_tuser[0], exp_w.dead));
                    if (m_tuser[1] !== exp_w.clamped)
                        flag_mismatch($sformatf("word %0d clamped %b, expected %b",
                                                words_checked, m_tuser[1], exp_w.clamped));
                end
            end
        end
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_MAX) begin
            $display("watchdog: no word moved for %0d cycles", STALL_MAX);
            $display("sliding_mode_position_controller_tb: done, errors");
            $finish;
        end
    end

    task automatic apb_write(input int unsigned idx, input logic [31:0] val);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 5'(idx * 4);
        pwdata  <= val;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // unmapped indexes are dropped by the block
        if (idx <= REG_SWITCHING_GAIN)
            gain_reg[idx] = val[30:0];
    endtask

    task automatic apb_read_check(input int unsigned idx);
        logic [31:0] got;
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= 5'(idx * 4);
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        got = prdata;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== {1'b0, gain_reg[idx]})
            flag_mismatch($sformatf("register %0d reads %h, expected %h",
                                    idx, got, {1'b0, gain_reg[idx]}));
    endtask

    task automatic add_word(input logic [31:0] t, input logic [31:0] a,
                            input logic [31:0] v);
        angle_word_t w;
        w.target   = t;
        w.measured = a;
        w.velocity = v;
        angle_pending.push_back(w);
    endtask

    task automatic queue_random_word();
        angle_word_t w;
        int pick, amp, noise, off;
        logic [31:0] corner [5];
        corner = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h1};
        pick = $urandom_range(99);
        if (pick < 60) begin
            // smooth motion with sensor noise of random size
            if ($urandom_range(49) == 0) traj_rate = 0;
            traj_rate += int'($urandom_range(8191)) - 4096;
            traj_pos  += traj_rate;
            amp   = 1 << $urandom_range(22);
            noise = int'($urandom_range(2 * amp)) - amp;
            w.target   = traj_pos;
            w.measured = traj_pos + noise;
            amp   = 1 << $urandom_range(20);
            w.velocity = traj_rate + int'($urandom_range(2 * amp)) - amp;
        end else if (pick < 75) begin
            // error right at the dead band edge
            off = int'(gain_reg[REG_DEAD_BAND]) + int'($urandom_range(2)) - 1;
            if ($urandom_range(1)) off = -off;
            w.target   = $urandom;
            w.measured = w.target + off;
            w.velocity = int'($urandom_range(1 << 18)) - (1 << 17);
        end else if (pick < 85) begin
            w.target   = corner[$urandom_range(4)];
            w.measured = corner[$urandom_range(4)];
            w.velocity = corner[$urandom_range(4)];
        end else begin
            w.target   = $urandom;
            w.measured = $urandom;
            w.velocity = $urandom;
        end
        angle_pending.push_back(w);
    endtask

    // wait until every word has gone through and the block has settled
    task automatic wait_drained();
        while (angle_pending.size() != 0 || s_tvalid || drive_expect.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_PAD) @(posedge aclk);
    endtask

    initial begin
        logic [31:0] vals [6];
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        // directed words with the reset gains
        add_word(32'h0, 32'h0, 32'h0);                         // zero error
        add_word(32'h0, 32'd65, 32'h0);                        // just inside band
        add_word(32'h0, 32'd66, 32'h0);                        // error equal to band
        add_word(32'h0, -32'sd66, 32'd5);
        add_word(32'h0, -32'sd65, 32'h0);
        add_word(32'h0001_0000, 32'h0001_012C, 32'h0001_0000); // small error on a ramp
        add_word(32'h0002_0000, 32'h0001_FED4, 32'h0001_0000);
        add_word(32'h0003_0000, 32'h0003_0100, 32'h0001_0000);
        add_word(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF); // saturated differences
        add_word(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        add_word(32'h8000_0000, 32'h8000_0000, 32'h0);
        add_word(32'h0, 32'h03E8_0000, 32'h0);                 // big error, clamps high
        add_word(32'h0, 32'hFC18_0000, 32'h8000_0000);         // clamps low
        add_word(32'd12345, 32'd13369, 32'hFFF0_0000);         // surface below -1.0
        add_word(32'hFFFF_FFFF, 32'h7FFF_0000, 32'h1);
        add_word(32'h5555_5555, 32'hAAAA_AAAA, 32'h3333_3333);
        add_word(32'hAAAA_AAAA, 32'h5555_5555, 32'hCCCC_CCCC);
        add_word(32'h0, 32'h0, 32'h7FFF_FFFF);                 // dead band after motion
        wait_drained();

        for (int p = 0; p < 8; p++) begin
            case (p)
                0: vals = '{32'd1310720, 32'd7864320, 32'd66, 32'd1638400000,
                            32'd52429, 32'd32768};
                1: vals = '{$urandom_range(50 << 16), $urandom_range(200 << 16),
                            $urandom_range(4096), $urandom_range(1 << 30, 1 << 16),
                            $urandom_range(2 << 16), $urandom_range(4 << 16)};
                // all ones on the bus, bit 31 must be dropped
                2: vals = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                            32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
                // zero band never selects, zero limit forces zero drive
                3: vals = '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0};
                4: vals = '{32'd1310720, 32'd7864320, 32'h1000_0000, 32'd100,
                            32'h0001_0000, 32'd32768};
                5: vals = '{$urandom_range(50 << 16), $urandom_range(200 << 16),
                            32'h0, 32'h0, $urandom_range(4 << 16),
                            $urandom_range(4 << 16)};
                6: vals = '{$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
                default: vals = '{$urandom_range(50 << 16), $urandom_range(200 << 16),
                                  32'd1, 32'h7FFF_FFFF, $urandom_range(2 << 16),
                                  $urandom_range(4 << 16)};
            endcase
            for (int i = 0; i < 6; i++)
                apb_write(i, vals[i]);
            if (p == 0) begin
                // writes above the last register must change nothing
                apb_write(REG_UNMAPPED_LO, $urandom);
                apb_write(REG_UNMAPPED_HI, $urandom);
            end
            for (int i = 0; i <= REG_SWITCHING_GAIN; i++)
                apb_read_check(i);

            case (p % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 55; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 55; end
                default: begin src_idle_pct = 36; sink_stall_pct = 36; end
            endcase
            traj_pos  = $urandom;
            traj_rate = 0;
            for (int n = 0; n < 200; n++)
                queue_random_word();
            // back up the output while the input side keeps offering
            if (p == 0) hold_requests++;
            wait_drained();
        end

        $display("checked %0d drive words over 8 gain settings, zero and all-ones among them,",
                 words_checked);
        $display("with four idle patterns and one long output hold: %0d in band, %0d clamped",
                 dead_seen, clamp_seen);
        if (mismatches == 0 && drive_expect.size() == 0) begin
            $display("sliding_mode_position_controller_tb: done, clean");
        end else begin
            $display("%0d mismatches, %0d words still expected", mismatches,
                     drive_expect.size());
            $display("sliding_mode_position_controller_tb: done, errors");
        end
        $finish;
    end

endmodule

FILE: files.f
src/smpc_pkg.sv
src/smpc_mul.sv
src/sliding_mode_position_controller.sv
tb/sv/sliding_mode_position_controller_tb.sv
